### rtl/nps_pkg.sv
// Shared types and constants for the next-permutation step block.
`timescale 1ns / 1ps

package nps_pkg;

    localparam int MAX_ELEMENTS = 8;
    localparam int ELEMENT_BITS = 4;
    localparam int WORD_BITS    = 32;
    localparam int FIT_LANES    = WORD_BITS / ELEMENT_BITS;
    localparam int LANES        = (MAX_ELEMENTS < FIT_LANES) ? MAX_ELEMENTS : FIT_LANES;
    localparam int IDX_W        = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CNT_W        = $clog2(LANES + 1);
    localparam int CFG_W        = 4;
    localparam int CFG_RESET    = 8;
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

    typedef logic [ELEMENT_BITS-1:0] t_elem;
    typedef t_elem [LANES-1:0]       t_lanes;

    typedef struct packed {
        t_lanes           lanes;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] pivot;
        logic             found;
    } t_work;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] level;
    } t_q_status;

endpackage

### rtl/nps_front.sv
// Front end: unpacks an item, clamps the element count and finds the pivot.
`timescale 1ns / 1ps

module nps_front (
    input  logic [nps_pkg::WORD_BITS-1:0] i_perm_in,
    input  logic [nps_pkg::CFG_W-1:0]     i_element_count,
    output nps_pkg::t_work                o_work
);

    logic [nps_pkg::CNT_W-1:0] n_count;
    nps_pkg::t_lanes           n_lanes;
    logic [nps_pkg::IDX_W-1:0] n_pivot;
    logic                      n_found;

    always_comb begin
        if (i_element_count == '0) begin
            n_count = nps_pkg::CNT_W'(1);
        end else if (int'(i_element_count) > nps_pkg::LANES) begin
            n_count = nps_pkg::CNT_W'(nps_pkg::LANES);
        end else begin
            n_count = nps_pkg::CNT_W'(i_element_count);
        end
    end

    always_comb begin
        for (int i = 0; i < nps_pkg::LANES; i++) begin
            if (i < int'(n_count)) begin
                n_lanes[i] = i_perm_in[i*nps_pkg::ELEMENT_BITS +: nps_pkg::ELEMENT_BITS];
            end else begin
                n_lanes[i] = '0;
            end
        end
    end

    // rightmost ascent wins
    always_comb begin
        n_pivot = '0;
        n_found = 1'b0;
        for (int i = 0; i < nps_pkg::LANES - 1; i++) begin
            if ((i + 1 < int'(n_count)) && (n_lanes[i] < n_lanes[i+1])) begin
                n_pivot = nps_pkg::IDX_W'(i);
                n_found = 1'b1;
            end
        end
    end

    always_comb begin
        o_work.lanes = n_lanes;
        o_work.count = n_count;
        o_work.pivot = n_pivot;
        o_work.found = n_found;
    end

endmodule

### rtl/nps_queue.sv
// Short queue of classified items between the front and back ends.
`timescale 1ns / 1ps

module nps_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  nps_pkg::t_work     i_work,
    input  logic               i_pop,
    output nps_pkg::t_work     o_work,
    output nps_pkg::t_q_status o_status
);

    nps_pkg::t_work               r_mem [nps_pkg::Q_DEPTH];
    logic [nps_pkg::Q_PTR_W-1:0]  r_wr_ptr;
    logic [nps_pkg::Q_PTR_W-1:0]  r_rd_ptr;
    logic [nps_pkg::Q_CNT_W-1:0]  r_level;
    logic [nps_pkg::Q_PTR_W-1:0]  n_wr_ptr;
    logic [nps_pkg::Q_PTR_W-1:0]  n_rd_ptr;
    logic [nps_pkg::Q_CNT_W-1:0]  n_level;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_level  = r_level;
        if (i_push) begin
            n_wr_ptr = (int'(r_wr_ptr) == nps_pkg::Q_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (int'(r_rd_ptr) == nps_pkg::Q_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_level = r_level + 1'b1;
        end else if (!i_push && i_pop) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_work;
        end
    end

    assign o_work         = r_mem[r_rd_ptr];
    assign o_status.level = r_level;
    assign o_status.empty = (r_level == '0);
    assign o_status.full  = (int'(r_level) == nps_pkg::Q_DEPTH);

endmodule

### rtl/nps_back.sv
// Back end: swaps the pivot, reverses the suffix and holds the result register.
`timescale 1ns / 1ps

module nps_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_work_valid,
    input  nps_pkg::t_work                i_work,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [nps_pkg::WORD_BITS-1:0] o_perm_out,
    output logic                          o_has_next
);

    logic                          r_valid;
    logic [nps_pkg::WORD_BITS-1:0] r_perm_out;
    logic                          r_has_next;
    logic [nps_pkg::IDX_W-1:0]     n_swap;
    nps_pkg::t_lanes               n_swapped;
    nps_pkg::t_lanes               n_result;
    logic [nps_pkg::WORD_BITS-1:0] n_packed;
    logic [nps_pkg::CNT_W:0]       n_src [nps_pkg::LANES];
    nps_pkg::t_elem                n_piv_val;

    assign o_pop = i_work_valid && (!r_valid || !i_stall);

    assign n_piv_val = i_work.lanes[i_work.pivot];

    // rightmost larger element after the pivot
    always_comb begin
        n_swap = i_work.pivot;
        for (int j = 0; j < nps_pkg::LANES; j++) begin
            if ((j > int'(i_work.pivot)) && (j < int'(i_work.count))
                    && (i_work.lanes[j] > n_piv_val)) begin
                n_swap = nps_pkg::IDX_W'(j);
            end
        end
    end

    always_comb begin
        n_swapped               = i_work.lanes;
        n_swapped[i_work.pivot] = i_work.lanes[n_swap];
        n_swapped[n_swap]       = n_piv_val;
    end

    always_comb begin
        for (int i = 0; i < nps_pkg::LANES; i++) begin
            n_src[i] = (nps_pkg::CNT_W+1)'(i_work.pivot) + (nps_pkg::CNT_W+1)'(i_work.count)
                       - (nps_pkg::CNT_W+1)'(i);
            if (!i_work.found || (i <= int'(i_work.pivot))) begin
                n_result[i] = i_work.found ? n_swapped[i] : i_work.lanes[i];
            end else if (i < int'(i_work.count)) begin
                n_result[i] = n_swapped[n_src[i][nps_pkg::IDX_W-1:0]];
            end else begin
                n_result[i] = '0;
            end
        end
    end

    always_comb begin
        n_packed = '0;
        for (int i = 0; i < nps_pkg::LANES; i++) begin
            n_packed[i*nps_pkg::ELEMENT_BITS +: nps_pkg::ELEMENT_BITS] = n_result[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_perm_out <= n_packed;
            r_has_next <= i_work.found;
        end
    end

    assign o_valid    = r_valid;
    assign o_perm_out = r_perm_out;
    assign o_has_next = r_has_next;

endmodule

### rtl/next_permutation_step.sv
// Top level of the lexicographic next-permutation step block.
`timescale 1ns / 1ps

// Usage:
//   Input channel: i_valid / o_stall carry i_perm_in, a packed vector of
//   4-bit elements with element 0 in the low bits. An item is taken on a
//   rising edge with i_valid high and o_stall low.
//   Output channel: o_valid / i_stall carry o_perm_out and o_has_next.
//   o_has_next low means the input was already in non-increasing order and
//   o_perm_out repeats it. Lanes at or above the element count read as zero.
//   Config: i_cfg_wr_en writes i_cfg_wr_data into the element count
//   (0 acts as 1, values above 8 act as 8); write only while idle.
//   One item per cycle is sustained while i_stall is low.
//   The front end classifies the item (count clamp, pivot search) in the
//   accept cycle; the back end swaps and reverses from a two-entry queue
//   into the output register.
//   Reset (synchronous, active low) empties the queue and output register
//   and sets the element count to 8.
//   When the receiver stalls, the output holds; the queue keeps taking items
//   until it is full, then o_stall rises.
module next_permutation_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [nps_pkg::CFG_W-1:0]     i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [nps_pkg::WORD_BITS-1:0] i_perm_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [nps_pkg::WORD_BITS-1:0] o_perm_out,
    output logic                          o_has_next
);

    logic [nps_pkg::CFG_W-1:0] r_element_count;
    nps_pkg::t_work            n_front_work;
    nps_pkg::t_work            n_back_work;
    nps_pkg::t_q_status        n_q_status;
    logic                      n_push;
    logic                      n_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_count <= nps_pkg::CFG_W'(nps_pkg::CFG_RESET);
        end else if (i_cfg_wr_en) begin
            r_element_count <= i_cfg_wr_data;
        end
    end

    assign o_stall = n_q_status.full;
    assign n_push  = i_valid && !n_q_status.full;

    nps_front u_front (
        .i_perm_in       (i_perm_in),
        .i_element_count (r_element_count),
        .o_work          (n_front_work)
    );

    nps_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (n_push),
        .i_work   (n_front_work),
        .i_pop    (n_pop),
        .o_work   (n_back_work),
        .o_status (n_q_status)
    );

    nps_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (!n_q_status.empty),
        .i_work       (n_back_work),
        .o_pop        (n_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_perm_out   (o_perm_out),
        .o_has_next   (o_has_next)
    );

`ifndef ASSERT_OFF
    a_q_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(n_q_status.level) <= nps_pkg::Q_DEPTH)
        else $error("queue level beyond depth");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (!n_q_status.empty || o_valid))
        else $error("accepted item lost");

    a_drain_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!n_q_status.empty && (!o_valid || !i_stall)) |=> o_valid)
        else $error("queued item not moved to output");
`endif

endmodule
